// ===== rtl/bdp_pkg.sv =====
`timescale 1ns / 1ps
// bdp_pkg: shared constants and types for the buck duty PID / soft-start core.
// No dependencies; used by the channel interfaces and the core.
package bdp_pkg;

    // Widths of the fixed fields
    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 10;
    localparam int GAIN_W   = 16;
    localparam int STEP_W   = 8;
    localparam int ERR_W    = 11;   // target - sample, signed
    localparam int DERR_W   = 12;   // e - e_prev, signed

    // Integral accumulator width
    localparam int SUM_W    = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Gain product widths (unsigned gain extended by one sign bit)
    localparam int P_W = GAIN_W + 1 + ERR_W;
    localparam int I_W = GAIN_W + 1 + SUM_W;
    localparam int D_W = GAIN_W + 1 + DERR_W;

    // Numerator width: holds 409600*s + 100*P + I + 10000*D with margin
    localparam int N_W = ((SUM_W + 17) > 43) ? SUM_W + 18 : 44;

    // Output scaling: duty = floor(N / (2^16 * 5))
    localparam int N_SHIFT  = 16;
    localparam int HI_W     = N_W - N_SHIFT;
    localparam int QIN_W    = 13;           // quotient input below 5 * 1024
    localparam int QSAT_LIM = 5 * 1024;
    localparam int RECIP_W  = 16;
    localparam int RECIP5   = 52429;        // ceil(2^18 / 5)
    localparam int RECIP_SH = 18;
    localparam int QPROD_W  = QIN_W + RECIP_W;

    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET = 3'd0,
        CFG_KP     = 3'd1,
        CFG_KI     = 3'd2,
        CFG_KD     = 3'd3,
        CFG_LIMIT  = 3'd4,
        CFG_STEP   = 3'd5
    } t_cfg_idx;

    // Reset values
    localparam logic [SAMPLE_W-1:0] TARGET_RST = 10'd512;
    localparam logic [GAIN_W-1:0]   KP_RST     = 16'd4096;
    localparam logic [GAIN_W-1:0]   KI_RST     = 16'd20;
    localparam logic [GAIN_W-1:0]   KD_RST     = 16'd0;
    localparam logic [DUTY_W-1:0]   LIMIT_RST  = 10'd512;
    localparam logic [STEP_W-1:0]   STEP_RST   = 8'd2;

    // Fields that ride along the pipeline next to the arithmetic
    typedef struct packed {
        logic              ramp;     // word produced by soft start
        logic [DUTY_W-1:0] rduty;    // soft-start duty
        logic              regl;     // mode after this word
    } t_side;

endpackage

// ===== rtl/bdp_in_if.sv =====
`timescale 1ns / 1ps
// bdp_in_if: valid/ready channel carrying one ADC sample word.
// Depends on bdp_pkg for field widths.
interface bdp_in_if;
    logic                          valid;
    logic                          ready;
    logic [bdp_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// ===== rtl/bdp_out_if.sv =====
`timescale 1ns / 1ps
// bdp_out_if: valid/ready channel carrying one duty result word.
// Depends on bdp_pkg for field widths.
interface bdp_out_if;
    logic                        valid;
    logic                        ready;
    logic [bdp_pkg::DUTY_W-1:0]  duty;
    logic                        regulating;

    modport source (output valid, output duty, output regulating, input ready);
    modport sink   (input valid, input duty, input regulating, output ready);
endinterface

// ===== rtl/buck_duty_pid_soft_start_core.sv =====
// Buck converter duty core: soft-start ramp, then PID regulation of the duty.
// Stages: error terms, gain products, partial sums, numerator, then the output register.
// Throughput: one sample per cycle; a stage loads when empty or when its word moves on,
// so the input stalls only while all five stages hold words and the output waits.
// Reset (i_rst_n low, synchronous): soft-start mode, duty/errors/sum cleared,
// registers at defaults, pipeline emptied.
`timescale 1ns / 1ps
// Depends on bdp_pkg, bdp_in_if and bdp_out_if.
module buck_duty_pid_soft_start_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bdp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bdp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    bdp_in_if.sink                          i_in,
    bdp_out_if.source                       o_out
);

    // Configuration registers
    logic [bdp_pkg::SAMPLE_W-1:0] r_target;
    logic [bdp_pkg::GAIN_W-1:0]   r_kp;
    logic [bdp_pkg::GAIN_W-1:0]   r_ki;
    logic [bdp_pkg::GAIN_W-1:0]   r_kd;
    logic [bdp_pkg::DUTY_W-1:0]   r_limit;
    logic [bdp_pkg::STEP_W-1:0]   r_step;

    // Controller state
    logic                                r_mode;
    logic [bdp_pkg::DUTY_W-1:0]          r_duty;
    logic signed [bdp_pkg::ERR_W-1:0]    r_prev_err;
    logic signed [bdp_pkg::SUM_W-1:0]    r_sum;

    // Pipeline valids and handshakes
    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic ld_o, ld4, ld3, ld2, ld1, accept;

    // Stage 1: error terms
    logic [bdp_pkg::SAMPLE_W-1:0]        r_s1_sample;
    logic signed [bdp_pkg::ERR_W-1:0]    r_s1_e;
    logic signed [bdp_pkg::DERR_W-1:0]   r_s1_de;
    logic signed [bdp_pkg::SUM_W-1:0]    r_s1_sum;
    bdp_pkg::t_side                      r_s1_side;
    // Stage 2: gain products
    logic [bdp_pkg::SAMPLE_W-1:0]        r_s2_sample;
    logic signed [bdp_pkg::P_W-1:0]      r_s2_p;
    logic signed [bdp_pkg::I_W-1:0]      r_s2_i;
    logic signed [bdp_pkg::D_W-1:0]      r_s2_d;
    bdp_pkg::t_side                      r_s2_side;
    // Stage 3: partial sums
    logic signed [bdp_pkg::N_W-1:0]      r_s3_a;
    logic signed [bdp_pkg::N_W-1:0]      r_s3_b;
    bdp_pkg::t_side                      r_s3_side;
    // Stage 4: numerator
    logic signed [bdp_pkg::N_W-1:0]      r_s4_n;
    bdp_pkg::t_side                      r_s4_side;
    // Output register
    logic [bdp_pkg::DUTY_W-1:0]          r_o_duty;
    logic                                r_o_regl;

    // Next-value signals
    logic signed [bdp_pkg::ERR_W-1:0]    n_e;
    logic signed [bdp_pkg::DERR_W-1:0]   n_de;
    logic signed [bdp_pkg::SUM_W:0]      n_sum_raw;
    logic signed [bdp_pkg::SUM_W-1:0]    n_sum;
    logic [bdp_pkg::DUTY_W:0]            n_ramp_raw;
    logic [bdp_pkg::DUTY_W-1:0]          n_ramp_duty;
    logic                                n_ramp_go;
    bdp_pkg::t_side                      n_side;
    logic [bdp_pkg::HI_W-1:0]            n_hi;
    logic [bdp_pkg::QPROD_W-1:0]         n_qprod;
    logic [bdp_pkg::DUTY_W-1:0]          n_pid_duty;

    // Stage advance: a stage loads when empty or when its word moves on
    always_comb begin
        ld_o   = !r_ov || o_out.ready;
        ld4    = !r_v4 || ld_o;
        ld3    = !r_v3 || ld4;
        ld2    = !r_v2 || ld3;
        ld1    = !r_v1 || ld2;
        accept = i_in.valid && ld1;
    end

    assign i_in.ready       = ld1;
    assign o_out.valid      = r_ov;
    assign o_out.duty       = r_o_duty;
    assign o_out.regulating = r_o_regl;

    // Error, saturating integral and soft-start step for the incoming word
    always_comb begin
        n_e  = bdp_pkg::ERR_W'($signed({1'b0, r_target}))
             - bdp_pkg::ERR_W'($signed({1'b0, i_in.sample}));
        n_de = bdp_pkg::DERR_W'(n_e) - bdp_pkg::DERR_W'(r_prev_err);

        n_sum_raw = (bdp_pkg::SUM_W + 1)'(r_sum) + (bdp_pkg::SUM_W + 1)'(n_e);
        if (n_sum_raw[bdp_pkg::SUM_W] != n_sum_raw[bdp_pkg::SUM_W-1]) begin
            // overflow: clamp toward the sign of the true sum
            n_sum = n_sum_raw[bdp_pkg::SUM_W]
                  ? {1'b1, {(bdp_pkg::SUM_W-1){1'b0}}}
                  : {1'b0, {(bdp_pkg::SUM_W-1){1'b1}}};
        end else begin
            n_sum = n_sum_raw[bdp_pkg::SUM_W-1:0];
        end

        n_ramp_go   = r_duty < r_limit;
        n_ramp_raw  = {1'b0, r_duty} + (bdp_pkg::DUTY_W + 1)'(r_step);
        n_ramp_duty = n_ramp_raw[bdp_pkg::DUTY_W] ? bdp_pkg::DUTY_MAX
                                                  : n_ramp_raw[bdp_pkg::DUTY_W-1:0];

        n_side.ramp  = !r_mode;
        n_side.rduty = (n_ramp_go) ? n_ramp_duty : r_duty;
        n_side.regl  = r_mode || !n_ramp_go;
    end

    // Duty from numerator: floor(N / 327680), zero when N <= 0, clamp at max
    always_comb begin
        n_hi    = r_s4_n[bdp_pkg::N_W-1:bdp_pkg::N_SHIFT];
        n_qprod = bdp_pkg::QPROD_W'(n_hi[bdp_pkg::QIN_W-1:0])
                * bdp_pkg::QPROD_W'(bdp_pkg::RECIP5);
        if (r_s4_n[bdp_pkg::N_W-1] || r_s4_n == '0) begin
            n_pid_duty = '0;
        end else if (n_hi >= bdp_pkg::HI_W'(bdp_pkg::QSAT_LIM)) begin
            n_pid_duty = bdp_pkg::DUTY_MAX;
        end else begin
            n_pid_duty = n_qprod[bdp_pkg::RECIP_SH +: bdp_pkg::DUTY_W];
        end
    end

    // Control state: configuration, mode, duty, previous error, sum, valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= bdp_pkg::TARGET_RST;
            r_kp       <= bdp_pkg::KP_RST;
            r_ki       <= bdp_pkg::KI_RST;
            r_kd       <= bdp_pkg::KD_RST;
            r_limit    <= bdp_pkg::LIMIT_RST;
            r_step     <= bdp_pkg::STEP_RST;
            r_mode     <= 1'b0;
            r_duty     <= '0;
            r_prev_err <= '0;
            r_sum      <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bdp_pkg::CFG_TARGET: r_target <= i_cfg_data[bdp_pkg::SAMPLE_W-1:0];
                    bdp_pkg::CFG_KP:     r_kp     <= i_cfg_data;
                    bdp_pkg::CFG_KI:     r_ki     <= i_cfg_data;
                    bdp_pkg::CFG_KD:     r_kd     <= i_cfg_data;
                    bdp_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[bdp_pkg::DUTY_W-1:0];
                    bdp_pkg::CFG_STEP:   r_step   <= i_cfg_data[bdp_pkg::STEP_W-1:0];
                    default: ;
                endcase
            end

            // state moves once per accepted word
            if (accept) begin
                r_prev_err <= n_e;
                r_sum      <= n_sum;
                if (!r_mode) begin
                    r_duty <= n_side.rduty;
                    r_mode <= n_side.regl;
                end
            end

            if (ld1)  r_v1 <= accept;
            if (ld2)  r_v2 <= r_v1;
            if (ld3)  r_v3 <= r_v2;
            if (ld4)  r_v4 <= r_v3;
            if (ld_o) r_ov <= r_v4;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_s1_sample <= i_in.sample;
            r_s1_e      <= n_e;
            r_s1_de     <= n_de;
            r_s1_sum    <= n_sum;
            r_s1_side   <= n_side;
        end
        // gain products
        if (ld2) begin
            r_s2_sample <= r_s1_sample;
            r_s2_p      <= bdp_pkg::P_W'($signed({1'b0, r_kp})) * bdp_pkg::P_W'(r_s1_e);
            r_s2_i      <= bdp_pkg::I_W'($signed({1'b0, r_ki})) * bdp_pkg::I_W'(r_s1_sum);
            r_s2_d      <= bdp_pkg::D_W'($signed({1'b0, r_kd})) * bdp_pkg::D_W'(r_s1_de);
            r_s2_side   <= r_s1_side;
        end
        // constant scaling and two partial sums
        if (ld3) begin
            r_s3_a    <= $signed(bdp_pkg::N_W'(r_s2_sample)) * bdp_pkg::N_W'(409600)
                       + bdp_pkg::N_W'(r_s2_p) * bdp_pkg::N_W'(100);
            r_s3_b    <= bdp_pkg::N_W'(r_s2_i)
                       + bdp_pkg::N_W'(r_s2_d) * bdp_pkg::N_W'(10000);
            r_s3_side <= r_s2_side;
        end
        if (ld4) begin
            r_s4_n    <= r_s3_a + r_s3_b;
            r_s4_side <= r_s3_side;
        end
        // result word: ramp duty during soft start, PID duty otherwise
        if (ld_o) begin
            r_o_duty <= r_s4_side.ramp ? r_s4_side.rduty : n_pid_duty;
            r_o_regl <= r_s4_side.regl;
        end
    end

endmodule

// ===== tb/buck_duty_pid_soft_start_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for buck_duty_pid_soft_start_core: directed table, random phases
// and an integrator soak, checked word by word against an in-bench duty predictor.
// Depends on bdp_pkg, bdp_in_if, bdp_out_if and the core RTL.
module buck_duty_pid_soft_start_core_tb;
    import bdp_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RST_CYCLES     = 6;
    localparam int SETTLE_CYCLES  = 12;        // well past the 5-stage pipeline
    localparam int CYCLE_LIMIT    = 3_000_000;
    localparam int SQUEEZE_CYCLES = 200;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_WORDS    = 80;
    localparam int SOAK_UP        = 70;        // large positive error into the integrator
    localparam int SOAK_DOWN      = 70;        // then large negative error

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [GAIN_W-1:0]    GAIN_MAX   = '1;
    localparam logic [SAMPLE_W-1:0]  LEVEL_MAX  = '1;

    // Fixed-point scaling of the regulate law
    localparam longint SAMPLE_SCALE = 409600;
    localparam longint P_SCALE      = 100;
    localparam longint D_SCALE      = 10000;
    localparam longint OUT_NUM      = 5;
    localparam longint OUT_DEN      = 1638400;
    localparam longint SUM_HI       = (longint'(1) <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO       = -SUM_HI - 1;

    typedef enum bit {ROW_WORD, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   sample;
        bit                    typed;
        logic [DUTY_W-1:0]     duty;
        logic                  regl;
    } t_plan_row;

    typedef struct {
        logic [DUTY_W-1:0] duty;
        logic              regl;
    } t_duty_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bdp_in_if  in_if ();
    bdp_out_if out_if ();

    buck_duty_pid_soft_start_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // Predictor copy of registers and loop state
    logic [SAMPLE_W-1:0]        m_target  = TARGET_RST;
    logic [GAIN_W-1:0]          m_kp      = KP_RST;
    logic [GAIN_W-1:0]          m_ki      = KI_RST;
    logic [GAIN_W-1:0]          m_kd      = KD_RST;
    logic [DUTY_W-1:0]          m_limit   = LIMIT_RST;
    logic [STEP_W-1:0]          m_step    = STEP_RST;
    logic                       m_regulate = 1'b0;
    logic [DUTY_W-1:0]          m_duty     = '0;
    logic signed [ERR_W-1:0]    m_prev_err = '0;
    logic signed [SUM_W-1:0]    m_err_sum  = '0;

    t_duty_word pending_duty_q[$];
    t_plan_row  plan[$];
    int         fail_cnt     = 0;
    int         burst_left   = 0;
    int         squeeze_req  = 0;
    int         squeeze_done = 0;
    int         cycle_cnt    = 0;

    // Typed expectation for the word on the input channel, set at the falling edge
    bit                row_typed = 1'b0;
    logic [DUTY_W-1:0] row_duty  = '0;
    logic              row_regl  = 1'b0;

    // One control tick of the loop: integrate, ramp or regulate, remember the error
    function automatic t_duty_word control_tick(logic [SAMPLE_W-1:0] smp);
        longint      err;
        longint      dlt;
        longint      acc;
        longint      num;
        longint      quo;
        int unsigned ramp;
        t_duty_word  res;
        err = longint'(m_target) - longint'(smp);
        dlt = err - longint'(m_prev_err);
        acc = longint'(m_err_sum) + err;
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        m_err_sum = acc[SUM_W-1:0];
        if (!m_regulate) begin
            if (m_duty < m_limit) begin
                ramp   = m_duty + m_step;
                m_duty = (ramp > DUTY_MAX) ? DUTY_MAX : ramp[DUTY_W-1:0];
            end else begin
                m_regulate = 1'b1;
            end
        end else begin
            num = SAMPLE_SCALE * longint'(smp) + P_SCALE * longint'(m_kp) * err
                + longint'(m_ki) * acc + D_SCALE * longint'(m_kd) * dlt;
            if (num <= 0) begin
                m_duty = '0;
            end else begin
                quo    = (num * OUT_NUM) / OUT_DEN;
                m_duty = (quo > DUTY_MAX) ? DUTY_MAX : quo[DUTY_W-1:0];
            end
        end
        m_prev_err = err[ERR_W-1:0];
        res.duty = m_duty;
        res.regl = m_regulate;
        return res;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r.kind   = ROW_CFG;
        r.idx    = idx;
        r.data   = data;
        r.sample = '0;
        r.typed  = 1'b0;
        r.duty   = '0;
        r.regl   = 1'b0;
        return r;
    endfunction

    function automatic t_plan_row word_row(logic [SAMPLE_W-1:0] smp);
        t_plan_row r;
        r.kind   = ROW_WORD;
        r.idx    = '0;
        r.data   = '0;
        r.sample = smp;
        r.typed  = 1'b0;
        r.duty   = '0;
        r.regl   = 1'b0;
        return r;
    endfunction

    function automatic t_plan_row known_row(logic [SAMPLE_W-1:0] smp,
                                            logic [DUTY_W-1:0] duty, logic regl);
        t_plan_row r;
        r       = word_row(smp);
        r.typed = 1'b1;
        r.duty  = duty;
        r.regl  = regl;
        return r;
    endfunction

    // Gains: mostly moderate so the duty stays off the rails, sometimes an extreme
    function automatic logic [GAIN_W-1:0] pick_gain(int unsigned cap);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return GAIN_MAX;
            default: return GAIN_W'($urandom_range(0, cap));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LEVEL_MAX;
            default: return SAMPLE_W'($urandom_range(0, LEVEL_MAX));
        endcase
    endfunction

    // Mostly samples near the target, as a closed loop would see, plus noise
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int v;
        if ($urandom_range(0, 9) < 7) begin
            v = int'(m_target) + int'($urandom_range(0, 64)) - 32;
            if (v < 0) v = 0;
            if (v > int'(LEVEL_MAX)) v = int'(LEVEL_MAX);
            return v[SAMPLE_W-1:0];
        end
        return SAMPLE_W'($urandom_range(0, LEVEL_MAX));
    endfunction

    // Register write: one enable pulse, predictor follows at the same edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_TARGET: m_target = data[SAMPLE_W-1:0];
            CFG_KP:     m_kp     = data[GAIN_W-1:0];
            CFG_KI:     m_ki     = data[GAIN_W-1:0];
            CFG_KD:     m_kd     = data[GAIN_W-1:0];
            CFG_LIMIT:  m_limit  = data[DUTY_W-1:0];
            CFG_STEP:   m_step   = data[STEP_W-1:0];
            default:    ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Offer one sample word; bursts of random length with random gaps between
    task automatic send_word(logic [SAMPLE_W-1:0] smp, bit typed,
                             logic [DUTY_W-1:0] duty, logic regl);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        @(negedge i_clk);
        row_typed = typed;
        row_duty  = duty;
        row_regl  = regl;
        in_if.valid  <= 1'b1;
        in_if.sample <= smp;
        burst_left--;
        forever begin
            @(posedge i_clk);
            if (in_if.ready) break;
        end
    endtask

    // Stop offering, let every pending duty word come out, then settle
    task automatic drain_pipeline();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_duty_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Output ready: segments with their own stall rate, plus long hold-offs on request
    initial begin
        int seg;
        int pct;
        out_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (squeeze_req != squeeze_done) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES - 1) @(negedge i_clk);
                squeeze_done++;
            end else begin
                seg = $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0:       pct = 0;
                    1:       pct = 25;
                    2:       pct = 50;
                    default: pct = 90;
                endcase
                repeat (seg) begin
                    @(negedge i_clk);
                    out_if.ready <= ($urandom_range(0, 99) >= pct);
                end
            end
        end
    end

    // Predict on each accepted sample, check each accepted duty word
    always @(posedge i_clk) begin
        t_duty_word want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                want = control_tick(in_if.sample);
                if (row_typed) begin
                    want.duty = row_duty;
                    want.regl = row_regl;
                end
                pending_duty_q.push_back(want);
            end
            if (out_if.valid && out_if.ready) begin
                if (pending_duty_q.size() == 0) begin
                    $error("duty word with none pending: duty %0d, regulating %0b",
                           out_if.duty, out_if.regulating);
                    fail_cnt++;
                end else begin
                    want = pending_duty_q.pop_front();
                    if (out_if.duty !== want.duty) begin
                        $error("duty: expected %0d, actual %0d", want.duty, out_if.duty);
                        fail_cnt++;
                    end
                    if (out_if.regulating !== want.regl) begin
                        $error("regulating: expected %0b, actual %0b",
                               want.regl, out_if.regulating);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // Main sequence
    initial begin
        bit after_word;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_if.valid  = 1'b0;
        in_if.sample = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Soft start with zero step: duty stays at zero
        plan.push_back(cfg_row(CFG_STEP, 16'd0));
        plan.push_back(cfg_row(CFG_LIMIT, 16'd1000));
        plan.push_back(known_row(10'd0,    10'd0, 1'b0));
        plan.push_back(known_row(10'd1023, 10'd0, 1'b0));
        plan.push_back(known_row(10'd512,  10'd0, 1'b0));
        // Full step to the top limit: ramp saturates at full duty, then regulate
        plan.push_back(cfg_row(CFG_STEP, 16'd255));
        plan.push_back(cfg_row(CFG_LIMIT, 16'd1023));
        plan.push_back(known_row(10'd300,  10'd255,  1'b0));
        plan.push_back(known_row(10'd700,  10'd510,  1'b0));
        plan.push_back(known_row(10'd512,  10'd765,  1'b0));
        plan.push_back(known_row(10'd600,  10'd1020, 1'b0));
        plan.push_back(known_row(10'd100,  10'd1023, 1'b0));
        plan.push_back(known_row(10'd900,  10'd1023, 1'b1));
        // All gains zero: duty is 1.25 times the sample, clipped
        plan.push_back(cfg_row(CFG_KP, 16'd0));
        plan.push_back(cfg_row(CFG_KI, 16'd0));
        plan.push_back(cfg_row(CFG_KD, 16'd0));
        plan.push_back(known_row(10'd1023, 10'd1023, 1'b1));
        plan.push_back(known_row(10'd0,    10'd0,    1'b1));
        plan.push_back(known_row(10'd800,  10'd1000, 1'b1));
        plan.push_back(known_row(10'd1,    10'd1,    1'b1));
        // Max proportional gain at both target extremes: rails high, then low
        plan.push_back(cfg_row(CFG_KP, 16'hFFFF));
        plan.push_back(cfg_row(CFG_TARGET, 16'd1023));
        plan.push_back(known_row(10'd0, 10'd1023, 1'b1));
        plan.push_back(cfg_row(CFG_TARGET, 16'd0));
        plan.push_back(known_row(10'd1023, 10'd0, 1'b1));
        // Max integral gain, then max derivative gain
        plan.push_back(cfg_row(CFG_KP, 16'd4096));
        plan.push_back(cfg_row(CFG_KI, 16'hFFFF));
        plan.push_back(cfg_row(CFG_TARGET, 16'd512));
        plan.push_back(word_row(10'd500));
        plan.push_back(word_row(10'd524));
        plan.push_back(cfg_row(CFG_KI, 16'd20));
        plan.push_back(cfg_row(CFG_KD, 16'hFFFF));
        plan.push_back(word_row(10'd0));
        plan.push_back(word_row(10'd1023));
        plan.push_back(word_row(10'd512));
        // Write to an unmapped index is dropped
        plan.push_back(cfg_row(CFG_UNUSED, 16'hFFFF));
        plan.push_back(cfg_row(CFG_KD, 16'd0));
        plan.push_back(word_row(10'd512));

        after_word = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                if (after_word) drain_pipeline();
                after_word = 1'b0;
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                after_word = 1'b1;
                send_word(plan[i].sample, plan[i].typed, plan[i].duty, plan[i].regl);
            end
        end

        // Random phases, each with a fresh register set
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain_pipeline();
            write_reg(CFG_TARGET, CFG_DATA_W'(pick_level()));
            write_reg(CFG_KP, pick_gain(16384));
            write_reg(CFG_KI, pick_gain(400));
            write_reg(CFG_KD, pick_gain(256));
            write_reg(CFG_LIMIT, CFG_DATA_W'(pick_level()));
            write_reg(CFG_STEP, CFG_DATA_W'($urandom_range(1, 255)));
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_UNUSED, CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
            end
            if (p == 1 || p == 5) squeeze_req++;
            repeat (PHASE_WORDS) send_word(pick_sample(), 1'b0, '0, 1'b0);
        end

        // Integrator soak: large positive error, then large negative error
        drain_pipeline();
        write_reg(CFG_KP, 16'd4096);
        write_reg(CFG_KI, 16'd20);
        write_reg(CFG_KD, 16'd0);
        write_reg(CFG_TARGET, 16'd1023);
        repeat (SOAK_UP) send_word(SAMPLE_W'($urandom_range(0, 3)), 1'b0, '0, 1'b0);
        drain_pipeline();
        write_reg(CFG_TARGET, 16'd0);
        squeeze_req++;
        repeat (SOAK_DOWN) send_word(SAMPLE_W'($urandom_range(1020, 1023)), 1'b0, '0, 1'b0);

        drain_pipeline();
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
